// ----- hw/rtl/rtnh_pkg.sv -----
// Shared types, constants and arithmetic helpers for the ray/triangle nearest-hit block.
// Used by rtnh_div and ray_triangle_nearest_hit.
`timescale 1ns / 1ps
`default_nettype none

package rtnh_pkg;

    localparam int MAX_TRIANGLES = 256;
    localparam int STORE_DEPTH   = MAX_TRIANGLES * 9;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int TRI_W         = $clog2(MAX_TRIANGLES);
    localparam int CNT_W         = TRI_W + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRI_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 2'd1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RAY   = 1'b1;

    localparam logic [1:0] CORNER_NONE = 2'd3;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_TRIANGLES);

    typedef struct packed {
        logic               mode;
        logic [7:0]         tri_index;
        logic [1:0]         corner;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               skip_valid;
        logic [7:0]         skip_index;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [7:0]         hit_index;
        logic signed [31:0] distance;
        logic signed [31:0] bary_u;
        logic signed [31:0] bary_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SELECT,
        ST_LOAD,
        ST_SUB,
        ST_CALC,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_TEST,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OPD_ZERO,
        OPD_DIR_X, OPD_DIR_Y, OPD_DIR_Z,
        OPD_E1_X,  OPD_E1_Y,  OPD_E1_Z,
        OPD_E2_X,  OPD_E2_Y,  OPD_E2_Z,
        OPD_TV_X,  OPD_TV_Y,  OPD_TV_Z,
        OPD_PV_X,  OPD_PV_Y,  OPD_PV_Z,
        OPD_QV_X,  OPD_QV_Y,  OPD_QV_Z,
        OPD_U,     OPD_V,
        OPD_P1_X,  OPD_P1_Y,  OPD_P1_Z
    } operand_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_PV_X, DST_PV_Y, DST_PV_Z,
        DST_QV_X, DST_QV_Y, DST_QV_Z,
        DST_DET,
        DST_NUM_T, DST_NUM_U, DST_NUM_V,
        DST_PT_X, DST_PT_Y, DST_PT_Z
    } dest_t;

    typedef struct packed {
        operand_t a;
        operand_t b;
        logic     neg;
        logic     first;
        operand_t init;
        logic     last;
        dest_t    dst;
    } uop_t;

    localparam logic [4:0] STEP_RAY_LAST = 5'd23;
    localparam logic [4:0] STEP_PT_FIRST = 5'd24;
    localparam logic [4:0] STEP_PT_LAST  = 5'd29;

    localparam logic [1:0] DIV_T = 2'd0;
    localparam logic [1:0] DIV_U = 2'd1;
    localparam logic [1:0] DIV_V = 2'd2;

    function automatic uop_t mk(operand_t a, operand_t b, logic neg, logic first,
                                operand_t init, logic last, dest_t dst);
        uop_t r;
        r.a     = a;
        r.b     = b;
        r.neg   = neg;
        r.first = first;
        r.init  = init;
        r.last  = last;
        r.dst   = dst;
        return r;
    endfunction

    // One product term per step; cross products, dot products, then the hit point.
    function automatic uop_t uop_at(logic [4:0] step);
        uop_t r;
        unique case (step)
            5'd0:  r = mk(OPD_DIR_Y, OPD_E2_Z, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd1:  r = mk(OPD_DIR_Z, OPD_E2_Y, 1'b1, 1'b0, OPD_ZERO, 1'b1, DST_PV_X);
            5'd2:  r = mk(OPD_DIR_Z, OPD_E2_X, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd3:  r = mk(OPD_DIR_X, OPD_E2_Z, 1'b1, 1'b0, OPD_ZERO, 1'b1, DST_PV_Y);
            5'd4:  r = mk(OPD_DIR_X, OPD_E2_Y, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd5:  r = mk(OPD_DIR_Y, OPD_E2_X, 1'b1, 1'b0, OPD_ZERO, 1'b1, DST_PV_Z);
            5'd6:  r = mk(OPD_TV_Y,  OPD_E1_Z, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd7:  r = mk(OPD_TV_Z,  OPD_E1_Y, 1'b1, 1'b0, OPD_ZERO, 1'b1, DST_QV_X);
            5'd8:  r = mk(OPD_TV_Z,  OPD_E1_X, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd9:  r = mk(OPD_TV_X,  OPD_E1_Z, 1'b1, 1'b0, OPD_ZERO, 1'b1, DST_QV_Y);
            5'd10: r = mk(OPD_TV_X,  OPD_E1_Y, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd11: r = mk(OPD_TV_Y,  OPD_E1_X, 1'b1, 1'b0, OPD_ZERO, 1'b1, DST_QV_Z);
            5'd12: r = mk(OPD_PV_X,  OPD_E1_X, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd13: r = mk(OPD_PV_Y,  OPD_E1_Y, 1'b0, 1'b0, OPD_ZERO, 1'b0, DST_NONE);
            5'd14: r = mk(OPD_PV_Z,  OPD_E1_Z, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_DET);
            5'd15: r = mk(OPD_QV_X,  OPD_E2_X, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd16: r = mk(OPD_QV_Y,  OPD_E2_Y, 1'b0, 1'b0, OPD_ZERO, 1'b0, DST_NONE);
            5'd17: r = mk(OPD_QV_Z,  OPD_E2_Z, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_NUM_T);
            5'd18: r = mk(OPD_PV_X,  OPD_TV_X, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd19: r = mk(OPD_PV_Y,  OPD_TV_Y, 1'b0, 1'b0, OPD_ZERO, 1'b0, DST_NONE);
            5'd20: r = mk(OPD_PV_Z,  OPD_TV_Z, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_NUM_U);
            5'd21: r = mk(OPD_QV_X,  OPD_DIR_X, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
            5'd22: r = mk(OPD_QV_Y,  OPD_DIR_Y, 1'b0, 1'b0, OPD_ZERO, 1'b0, DST_NONE);
            5'd23: r = mk(OPD_QV_Z,  OPD_DIR_Z, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_NUM_V);
            5'd24: r = mk(OPD_U,     OPD_E1_X, 1'b0, 1'b1, OPD_P1_X, 1'b0, DST_NONE);
            5'd25: r = mk(OPD_V,     OPD_E2_X, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_PT_X);
            5'd26: r = mk(OPD_U,     OPD_E1_Y, 1'b0, 1'b1, OPD_P1_Y, 1'b0, DST_NONE);
            5'd27: r = mk(OPD_V,     OPD_E2_Y, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_PT_Y);
            5'd28: r = mk(OPD_U,     OPD_E1_Z, 1'b0, 1'b1, OPD_P1_Z, 1'b0, DST_NONE);
            5'd29: r = mk(OPD_V,     OPD_E2_Z, 1'b0, 1'b0, OPD_ZERO, 1'b1, DST_PT_Z);
            default: r = mk(OPD_ZERO, OPD_ZERO, 1'b0, 1'b1, OPD_ZERO, 1'b0, DST_NONE);
        endcase
        return r;
    endfunction

    // Q16.16 product, truncated toward zero.
    function automatic logic signed [47:0] fmul(logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p[63] ? (p + 64'sd65535) : p;
        return $signed(adj[63:16]);
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_sub(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            r = d[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            r = d[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rtnh_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtnh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2304
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rtnh_div.sv -----
// Radix-2 restoring divider: sat32((num * 2^16) / den), truncated toward zero.
// Depends on rtnh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtnh_div
    import rtnh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output div_status_t             status,
    output logic signed [31:0]      quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [47:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic signed [31:0] quo_reg;

    logic [32:0] shifted;
    logic        fits;
    logic [31:0] rem_next;
    logic [47:0] dvd_next;
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic signed [31:0] quo_next;

    always_comb
    begin
        num_mag  = num[31] ? (32'd0 - num) : num;
        den_mag  = den[31] ? (32'd0 - den) : den;
        shifted  = {rem_reg, dvd_reg[47]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
        dvd_next = {dvd_reg[46:0], fits};
        if (neg_reg)
        begin
            quo_next = (dvd_next > 48'h80000000) ? 32'sh80000000 : 32'(48'd0 - dvd_next);
        end
        else
        begin
            quo_next = (dvd_next > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : dvd_next[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[31] ^ den[31];
            dvd_reg <= {num_mag, 16'd0};
            rem_reg <= '0;
            den_reg <= den_mag;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            if (cnt_reg == 6'd47)
            begin
                quo_reg <= quo_next;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quo         = quo_reg;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ray_triangle_nearest_hit.sv -----
// Top level: nearest ray/triangle hit (Moller-Trumbore, Q16.16) over a vertex memory.
// Depends on rtnh_pkg, rtnh_ram and rtnh_div.
//
// Usage:
//   in channel (in_valid/in_stall/in_data): mode 0 writes one triangle corner,
//   mode 1 casts a ray. out channel (out_valid/out_stall/out_data) returns one
//   result per ray, none per corner write. cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) sets triangle_count (0) and epsilon (1); write it only
//   while the block is idle. cfg_ready is always high.
//   A corner write holds the input through the transfer, then 3 memory writes.
//   A ray, for each tested triangle, reads its nine vertex words from memory,
//   forms the shared multiplier terms and runs three divisions, plus control
//   steps; a triangle with zero determinant skips the divisions, a skipped one
//   only passes the select step, and a new nearest hit adds the hit point.
//   The single multiply-accumulate unit and the bit-serial divider set the rate.
//   One item is worked at a time; the next input transfer is taken while a
//   finished result still waits in the output register.
//   Reset returns the block to idle with triangle_count 0 and epsilon 7; the
//   vertex memory is not cleared and must be written before use.
//   While out_stall holds a result, a finished ray waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_nearest_hit
    import rtnh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]  tri_count_reg;
    logic [15:0]       eps_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [3:0]        cnt_reg;
    logic [4:0]        step_reg;
    logic              phase_reg;
    logic [1:0]        div_sel_reg;
    logic              found_reg;
    logic [TRI_W-1:0]  best_idx_reg;
    logic              out_valid_reg;

    in_item_t          item_reg;
    out_item_t         out_data_reg;
    logic [ADDR_W-1:0] base_reg;

    logic signed [31:0] p1x_reg, p1y_reg, p1z_reg;
    logic signed [31:0] c1x_reg, c1y_reg, c1z_reg;
    logic signed [31:0] c2x_reg, c2y_reg, c2z_reg;
    logic signed [31:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [31:0] e2x_reg, e2y_reg, e2z_reg;
    logic signed [31:0] tvx_reg, tvy_reg, tvz_reg;
    logic signed [31:0] pvx_reg, pvy_reg, pvz_reg;
    logic signed [31:0] qvx_reg, qvy_reg, qvz_reg;
    logic signed [31:0] det_reg, num_t_reg, num_u_reg, num_v_reg;
    logic signed [31:0] t_reg, u_reg, v_reg;
    logic signed [31:0] best_t_reg, best_u_reg, best_v_reg;
    logic signed [31:0] best_px_reg, best_py_reg, best_pz_reg;
    logic signed [63:0] prod_reg;
    logic signed [49:0] acc_reg;

    uop_t               uop;
    logic signed [31:0] op_a, op_b, op_init;
    logic signed [47:0] fprod;
    logic signed [49:0] acc_base, acc_sum;
    logic signed [31:0] acc_sat;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;
    logic [ADDR_W-1:0]  wr_base;

    logic               div_start;
    logic signed [31:0] div_num;
    div_status_t        div_status;
    logic signed [31:0] div_quo;

    logic               in_xfer;
    logic               out_free;
    logic               hit_pass;
    logic signed [33:0] t34, u34, v34, eps34, bt34;
    logic [CNT_W-1:0]   cnt_clamp;

    function automatic logic signed [31:0] pick(operand_t s,
        logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] dz,
        logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
        logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz,
        logic signed [31:0] tx, logic signed [31:0] ty, logic signed [31:0] tz,
        logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
        logic signed [31:0] qx, logic signed [31:0] qy, logic signed [31:0] qz,
        logic signed [31:0] uu, logic signed [31:0] vv,
        logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz);
        logic signed [31:0] r;
        unique case (s)
            OPD_ZERO:  r = '0;
            OPD_DIR_X: r = dx;
            OPD_DIR_Y: r = dy;
            OPD_DIR_Z: r = dz;
            OPD_E1_X:  r = ax;
            OPD_E1_Y:  r = ay;
            OPD_E1_Z:  r = az;
            OPD_E2_X:  r = bx;
            OPD_E2_Y:  r = by;
            OPD_E2_Z:  r = bz;
            OPD_TV_X:  r = tx;
            OPD_TV_Y:  r = ty;
            OPD_TV_Z:  r = tz;
            OPD_PV_X:  r = px;
            OPD_PV_Y:  r = py;
            OPD_PV_Z:  r = pz;
            OPD_QV_X:  r = qx;
            OPD_QV_Y:  r = qy;
            OPD_QV_Z:  r = qz;
            OPD_U:     r = uu;
            OPD_V:     r = vv;
            OPD_P1_X:  r = ox;
            OPD_P1_Y:  r = oy;
            OPD_P1_Z:  r = oz;
            default:   r = '0;
        endcase
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        uop     = uop_at(step_reg);
        op_a    = pick(uop.a, item_reg.dir_x, item_reg.dir_y, item_reg.dir_z,
                       e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg,
                       tvx_reg, tvy_reg, tvz_reg, pvx_reg, pvy_reg, pvz_reg,
                       qvx_reg, qvy_reg, qvz_reg, u_reg, v_reg,
                       p1x_reg, p1y_reg, p1z_reg);
        op_b    = pick(uop.b, item_reg.dir_x, item_reg.dir_y, item_reg.dir_z,
                       e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg,
                       tvx_reg, tvy_reg, tvz_reg, pvx_reg, pvy_reg, pvz_reg,
                       qvx_reg, qvy_reg, qvz_reg, u_reg, v_reg,
                       p1x_reg, p1y_reg, p1z_reg);
        op_init = pick(uop.init, item_reg.dir_x, item_reg.dir_y, item_reg.dir_z,
                       e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg,
                       tvx_reg, tvy_reg, tvz_reg, pvx_reg, pvy_reg, pvz_reg,
                       qvx_reg, qvy_reg, qvz_reg, u_reg, v_reg,
                       p1x_reg, p1y_reg, p1z_reg);
        fprod    = fmul(prod_reg);
        acc_base = uop.first ? {{18{op_init[31]}}, op_init} : acc_reg;
        acc_sum  = uop.neg ? (acc_base - {{2{fprod[47]}}, fprod})
                           : (acc_base + {{2{fprod[47]}}, fprod});
        acc_sat  = sat32(acc_sum);
    end

    always_comb
    begin
        t34   = {{2{t_reg[31]}}, t_reg};
        u34   = {{2{u_reg[31]}}, u_reg};
        v34   = {{2{v_reg[31]}}, v_reg};
        bt34  = {{2{best_t_reg[31]}}, best_t_reg};
        eps34 = {18'd0, eps_reg};
        hit_pass = (t34 > eps34)
                && (u34 >= -eps34) && (u34 <= 34'sd65536 + eps34)
                && (v34 >= -eps34) && (v34 <= 34'sd65536 + eps34)
                && (u34 + v34 < 34'sd65536 + eps34)
                && (!found_reg || (t34 < bt34));
    end

    assign cnt_clamp = (tri_count_reg > MAX_COUNT) ? MAX_COUNT : tri_count_reg;

    always_comb
    begin
        wr_base   = ADDR_W'({item_reg.tri_index, 3'd0}) + ADDR_W'(item_reg.tri_index)
                  + ADDR_W'({item_reg.corner, 1'b0}) + ADDR_W'(item_reg.corner);
        ram_waddr = wr_base + ADDR_W'(cnt_reg);
        unique case (cnt_reg[1:0])
            2'd0:    ram_wdata = item_reg.pos_x;
            2'd1:    ram_wdata = item_reg.pos_y;
            default: ram_wdata = item_reg.pos_z;
        endcase
        ram_raddr = base_reg + ((cnt_reg < 4'd9) ? ADDR_W'(cnt_reg) : '0);
        unique case (div_sel_reg)
            DIV_T:   div_num = num_t_reg;
            DIV_U:   div_num = num_u_reg;
            default: div_num = num_v_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.mode == MODE_RAY)
                    begin
                        state_next = ST_SELECT;
                    end
                    else if (in_data.corner != CORNER_NONE)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
                if (cnt_reg == 4'd2)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SELECT:
            begin
                if (idx_reg >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!(item_reg.skip_valid && (idx_reg == CNT_W'(item_reg.skip_index))))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == 4'd9)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (phase_reg && (step_reg == STEP_RAY_LAST))
                begin
                    state_next = ST_CHECK;
                end
                else if (phase_reg && (step_reg == STEP_PT_LAST))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_CHECK:
            begin
                state_next = (det_reg == '0) ? ST_NEXT : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = (div_sel_reg == DIV_V) ? ST_TEST : ST_DIV_GO;
                end
            end
            ST_TEST:
            begin
                state_next = hit_pass ? ST_CALC : ST_NEXT;
            end
            ST_NEXT:
            begin
                state_next = ST_SELECT;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_count_reg <= '0;
            eps_reg       <= 16'd7;
            n_reg         <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            div_sel_reg   <= DIV_T;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TRI_COUNT)
                begin
                    tri_count_reg <= cfg_data[CNT_W-1:0];
                end
                else if (cfg_index == CFG_EPSILON)
                begin
                    eps_reg <= cfg_data;
                end
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_xfer)
                    begin
                        n_reg        <= cnt_clamp;
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        best_idx_reg <= '0;
                    end
                end
                ST_WRITE:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SELECT:
                begin
                    cnt_reg     <= '0;
                    step_reg    <= '0;
                    phase_reg   <= 1'b0;
                    div_sel_reg <= DIV_T;
                    if ((idx_reg < n_reg) && item_reg.skip_valid
                        && (idx_reg == CNT_W'(item_reg.skip_index)))
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_CALC:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_status.done && (div_sel_reg != DIV_V))
                    begin
                        div_sel_reg <= div_sel_reg + 2'd1;
                    end
                end
                ST_TEST:
                begin
                    step_reg  <= STEP_PT_FIRST;
                    phase_reg <= 1'b0;
                    if (hit_pass)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= idx_reg[TRI_W-1:0];
                    end
                end
                ST_NEXT:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                best_t_reg  <= '0;
                best_u_reg  <= '0;
                best_v_reg  <= '0;
                best_px_reg <= '0;
                best_py_reg <= '0;
                best_pz_reg <= '0;
            end
            ST_SELECT:
            begin
                base_reg <= ADDR_W'({idx_reg[TRI_W-1:0], 3'd0}) + ADDR_W'(idx_reg[TRI_W-1:0]);
            end
            ST_LOAD:
            begin
                unique case (cnt_reg)
                    4'd1:    p1x_reg <= ram_rdata;
                    4'd2:    p1y_reg <= ram_rdata;
                    4'd3:    p1z_reg <= ram_rdata;
                    4'd4:    c1x_reg <= ram_rdata;
                    4'd5:    c1y_reg <= ram_rdata;
                    4'd6:    c1z_reg <= ram_rdata;
                    4'd7:    c2x_reg <= ram_rdata;
                    4'd8:    c2y_reg <= ram_rdata;
                    4'd9:    c2z_reg <= ram_rdata;
                    default:
                    begin
                    end
                endcase
            end
            ST_SUB:
            begin
                e1x_reg <= sat_sub(c1x_reg, p1x_reg);
                e1y_reg <= sat_sub(c1y_reg, p1y_reg);
                e1z_reg <= sat_sub(c1z_reg, p1z_reg);
                e2x_reg <= sat_sub(c2x_reg, p1x_reg);
                e2y_reg <= sat_sub(c2y_reg, p1y_reg);
                e2z_reg <= sat_sub(c2z_reg, p1z_reg);
                tvx_reg <= sat_sub(item_reg.pos_x, p1x_reg);
                tvy_reg <= sat_sub(item_reg.pos_y, p1y_reg);
                tvz_reg <= sat_sub(item_reg.pos_z, p1z_reg);
            end
            ST_CALC:
            begin
                if (!phase_reg)
                begin
                    prod_reg <= 64'(op_a) * 64'(op_b);
                end
                else
                begin
                    acc_reg <= acc_sum;
                    if (uop.last)
                    begin
                        unique case (uop.dst)
                            DST_PV_X:  pvx_reg     <= acc_sat;
                            DST_PV_Y:  pvy_reg     <= acc_sat;
                            DST_PV_Z:  pvz_reg     <= acc_sat;
                            DST_QV_X:  qvx_reg     <= acc_sat;
                            DST_QV_Y:  qvy_reg     <= acc_sat;
                            DST_QV_Z:  qvz_reg     <= acc_sat;
                            DST_DET:   det_reg     <= acc_sat;
                            DST_NUM_T: num_t_reg   <= acc_sat;
                            DST_NUM_U: num_u_reg   <= acc_sat;
                            DST_NUM_V: num_v_reg   <= acc_sat;
                            DST_PT_X:  best_px_reg <= acc_sat;
                            DST_PT_Y:  best_py_reg <= acc_sat;
                            DST_PT_Z:  best_pz_reg <= acc_sat;
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    unique case (div_sel_reg)
                        DIV_T:   t_reg <= div_quo;
                        DIV_U:   u_reg <= div_quo;
                        default: v_reg <= div_quo;
                    endcase
                end
            end
            ST_TEST:
            begin
                if (hit_pass)
                begin
                    best_t_reg <= t_reg;
                    best_u_reg <= u_reg;
                    best_v_reg <= v_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.hit       <= found_reg;
                    out_data_reg.hit_index <= 8'(best_idx_reg);
                    out_data_reg.distance  <= best_t_reg;
                    out_data_reg.bary_u    <= best_u_reg;
                    out_data_reg.bary_v    <= best_v_reg;
                    out_data_reg.point_x   <= best_px_reg;
                    out_data_reg.point_y   <= best_py_reg;
                    out_data_reg.point_z   <= best_pz_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    rtnh_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_vertex_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rtnh_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (det_reg),
        .status (div_status),
        .quo    (div_quo)
    );

`ifndef NO_ASSERTIONS
    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (idx_reg < n_reg))
        else $error("triangle fetch beyond count");
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");
    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> out_valid_reg)
        else $error("finished ray not posted");
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> (best_idx_reg == '0))
        else $error("index kept without hit");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for ray_triangle_nearest_hit: triangle corner writes and ray casts, with each
// ray result checked against an in-bench nearest-hit predictor. Depends on rtnh_pkg and the
// ray_triangle_nearest_hit RTL.
`timescale 1ns / 1ps

module testbench;
    import rtnh_pkg::*;

    localparam longint ONE_Q = 65536;
    localparam int     WATCHDOG_LIMIT = 400000;
    localparam int     CORNER_WORDS = MAX_TRIANGLES * 3;

    typedef longint vec_t [3];

    class hit_scoreboard;
        logic signed [31:0] vstore [STORE_DEPTH];
        int unsigned        tri_count;
        int unsigned        eps;
        out_item_t          hits_due [$];
        int                 errors;

        function new();
            tri_count = 0;
            eps = 7;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TRI_COUNT)
                tri_count = val & 16'h01FF;
            else if (idx == CFG_EPSILON)
                eps = val;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b) / ONE_Q;
        endfunction

        function vec_t vdiff(vec_t a, vec_t b);
            vec_t r;
            for (int k = 0; k < 3; k++)
                r[k] = sat(a[k] - b[k]);
            return r;
        endfunction

        function vec_t vcross(vec_t a, vec_t b);
            vec_t r;
            r[0] = sat(qmul(a[1], b[2]) - qmul(a[2], b[1]));
            r[1] = sat(qmul(a[2], b[0]) - qmul(a[0], b[2]));
            r[2] = sat(qmul(a[0], b[1]) - qmul(a[1], b[0]));
            return r;
        endfunction

        function longint vdot(vec_t a, vec_t b);
            return sat(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
        endfunction

        function vec_t corner_at(int tri_i, int c);
            vec_t r;
            for (int k = 0; k < 3; k++)
                r[k] = vstore[(tri_i * 3 + c) * 3 + k];
            return r;
        endfunction

        function void note_input(in_item_t it);
            vec_t org, dir, p1, e1, e2, tv, pv, qv;
            longint det, t, u, v, e;
            longint best_t;
            int n;
            bit found;
            out_item_t res;
            org[0] = it.pos_x;
            org[1] = it.pos_y;
            org[2] = it.pos_z;
            if (it.mode == MODE_WRITE) begin
                if (it.corner != CORNER_NONE) begin
                    for (int k = 0; k < 3; k++)
                        vstore[(it.tri_index * 3 + it.corner) * 3 + k] = 32'(org[k]);
                end
                return;
            end
            dir[0] = it.dir_x;
            dir[1] = it.dir_y;
            dir[2] = it.dir_z;
            n = (tri_count > MAX_TRIANGLES) ? MAX_TRIANGLES : tri_count;
            e = eps;
            found = 0;
            best_t = 0;
            res = '0;
            for (int i = 0; i < n; i++) begin
                if (it.skip_valid && i == it.skip_index)
                    continue;
                p1 = corner_at(i, 0);
                e1 = vdiff(corner_at(i, 1), p1);
                e2 = vdiff(corner_at(i, 2), p1);
                tv = vdiff(org, p1);
                pv = vcross(dir, e2);
                qv = vcross(tv, e1);
                det = vdot(pv, e1);
                if (det == 0)
                    continue;
                t = sat((vdot(qv, e2) * ONE_Q) / det);
                u = sat((vdot(pv, tv) * ONE_Q) / det);
                v = sat((vdot(qv, dir) * ONE_Q) / det);
                if (!(t > e))
                    continue;
                if (u < -e || u > ONE_Q + e || v < -e || v > ONE_Q + e)
                    continue;
                if (!(u + v < ONE_Q + e))
                    continue;
                if (!found || t < best_t) begin
                    found = 1;
                    best_t = t;
                    res.hit = 1'b1;
                    res.hit_index = i[7:0];
                    res.distance = t[31:0];
                    res.bary_u = u[31:0];
                    res.bary_v = v[31:0];
                    res.point_x = 32'(sat(p1[0] + qmul(u, e1[0]) + qmul(v, e2[0])));
                    res.point_y = 32'(sat(p1[1] + qmul(u, e1[1]) + qmul(v, e2[1])));
                    res.point_z = 32'(sat(p1[2] + qmul(u, e1[2]) + qmul(v, e2[2])));
                end
            end
            hits_due = {hits_due, res};
        endfunction

        task check_field(string name, longint got, longint want);
            if (got != want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check(out_item_t got);
            out_item_t want;
            if (hits_due.size() == 0) begin
                report($sformatf("unexpected result %0h", got));
                return;
            end
            want = hits_due.pop_front();
            check_field("hit", got.hit, want.hit);
            check_field("hit_index", got.hit_index, want.hit_index);
            check_field("distance", got.distance, want.distance);
            check_field("bary_u", got.bary_u, want.bary_u);
            check_field("bary_v", got.bary_v, want.bary_v);
            check_field("point_x", got.point_x, want.point_x);
            check_field("point_y", got.point_y, want.point_y);
            check_field("point_z", got.point_z, want.point_z);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hit_scoreboard sb = new();
    bit            calm = 0;
    int            quiet_cycles = 0;
    int            corner_ptr = 0;

    ray_triangle_nearest_hit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_data);
        out_stall <= !calm && ($urandom_range(99) < 30);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(in_item_t it);
        while (!calm && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // drain: no transfer in flight and nothing still expected
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.hits_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int rnd_q(int span);
        return int'($urandom_range(2 * span * 65536)) - span * 65536;
    endfunction

    function automatic in_item_t corner_item(int tri_i, int c, int x, int y, int z);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.mode = MODE_WRITE;
        it.tri_index = tri_i[7:0];
        it.corner = c[1:0];
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    function automatic in_item_t ray_item(int x, int y, int z, int dx, int dy, int dz,
                                          bit sv, int si);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.mode = MODE_RAY;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.dir_x = dx;
        it.dir_y = dy;
        it.dir_z = dz;
        it.skip_valid = sv;
        it.skip_index = si[7:0];
        return it;
    endfunction

    function automatic in_item_t scene_corner(int tri_i, int c);
        return corner_item(tri_i, c, rnd_q(4), rnd_q(4), rnd_q(2) + 4 * 65536);
    endfunction

    function automatic in_item_t scene_ray();
        return ray_item(rnd_q(2), rnd_q(2), rnd_q(1), rnd_q(1) / 2, rnd_q(1) / 2, 65536,
                        $urandom_range(3) == 0, $urandom_range(5));
    endfunction

    function automatic in_item_t noise_item();
        return in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom});
    endfunction

    // grows the fully written triangle prefix one corner at a time
    task automatic extend_store();
        send(scene_corner(corner_ptr / 3, corner_ptr % 3));
        corner_ptr++;
    endtask

    task automatic random_item(int ready);
        int r;
        in_item_t it;
        r = $urandom_range(99);
        if (r < 45) begin
            send(scene_ray());
        end else if (r < 50) begin
            it = noise_item();
            it.mode = MODE_RAY;
            send(it);
        end else if (r < 80 && corner_ptr < CORNER_WORDS) begin
            extend_store();
        end else if (r < 95) begin
            send(scene_corner($urandom_range(ready - 1), $urandom_range(2)));
        end else begin
            it = noise_item();
            it.mode = MODE_WRITE;
            send(it);
        end
    endtask

    initial
    begin
        int ready;
        int cnt;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: no triangles, so a miss
        send(ray_item(0, 0, 0, 0, 0, 65536, 0, 0));
        settle();
        write_reg(CFG_TRI_COUNT, 3);
        // unit triangle at z=5, a duplicate for the tie, and a degenerate one
        for (int t = 0; t < 2; t++) begin
            send(corner_item(t, 0, 0, 0, 5 * 65536));
            send(corner_item(t, 1, 65536, 0, 5 * 65536));
            send(corner_item(t, 2, 0, 65536, 5 * 65536));
        end
        send(corner_item(2, 0, 0, 0, 65536));
        send(corner_item(2, 1, 65536, 65536, 65536));
        send(corner_item(2, 2, 2 * 65536, 2 * 65536, 65536));
        send(corner_item(2, CORNER_NONE, 32'h7FFFFFFF, 32'h80000000, 12345));
        corner_ptr = 9;
        send(ray_item(16384, 16384, 0, 0, 0, 65536, 0, 0));
        send(ray_item(0, 16384, 0, 0, 0, 65536, 0, 0));
        send(ray_item(16384, 16384, 0, 0, 0, 65536, 1, 0));
        send(ray_item(16384, 16384, 0, 0, 0, -65536, 0, 0));
        send(ray_item(5 * 65536, 5 * 65536, 0, 0, 0, 65536, 0, 0));
        send(ray_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0));
        send(ray_item(16384, 16384, 0, 0, 0, 0, 0, 0));

        for (int p = 0; p < 8; p++) begin
            settle();
            ready = corner_ptr / 3;
            cnt = (p == 2) ? 0 : $urandom_range(1, (ready < 4) ? ready : 4);
            write_reg(CFG_TRI_COUNT, 16'(cnt));
            case (p % 4)
                0: write_reg(CFG_EPSILON, 0);
                1: write_reg(CFG_EPSILON, 7);
                2: write_reg(CFG_EPSILON, 16'hFFFF);
                default: write_reg(CFG_EPSILON, 16'($urandom_range(16'hFFFF)));
            endcase
            calm = (p == 5);
            for (int k = 0; k < 200; k++) begin
                if (p == 3 && k == 100) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.hits_due.size() != 0)
                        @(posedge clk);
                end
                random_item(corner_ptr / 3);
            end
        end
        calm = 0;

        while (corner_ptr < CORNER_WORDS)
            extend_store();
        settle();
        write_reg(CFG_TRI_COUNT, 16'(MAX_TRIANGLES));
        write_reg(CFG_EPSILON, 7);
        send(scene_ray());
        settle();
        write_reg(CFG_TRI_COUNT, 16'hFFFF);
        write_reg(CFG_EPSILON, 16'($urandom_range(16'hFFFF)));
        send(ray_item(rnd_q(2), rnd_q(2), 0, 0, 0, 65536, 1, $urandom_range(255)));
        settle();

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rtnh_pkg.sv
hw/rtl/rtnh_ram.sv
hw/rtl/rtnh_div.sv
hw/rtl/ray_triangle_nearest_hit.sv
dv/testbench.sv
